// ===== rtl/lsec_pkg.sv =====
// Shared types and constants of the LED strip effect controller.
package lsec_pkg;

    // Width of the volume bar threshold: volume * LED count + rounding term.
    localparam int THRESH_W = 17;

    // Depth of the redraw queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Colour levels on the 0..100 scale.
    localparam logic [6:0] LEVEL_FULL = 7'd100;
    localparam logic [6:0] LEVEL_HALF = 7'd50;
    localparam logic [6:0] LEVEL_ZERO = 7'd0;

    typedef struct packed {
        logic [6:0] red;
        logic [6:0] green;
        logic [6:0] blue;
    } rgb_t;

    // One redraw of the whole strip.
    typedef struct packed {
        logic                is_volume;
        logic [THRESH_W-1:0] threshold;
        rgb_t                colour;
    } job_t;

    // Queue status seen by the producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/led_strip_effect_controller.sv =====
// LED strip effect controller top level: register port, front, queue and back.
//
// Input channel (s_*): one word is either a command message (s_tuser = 0) or a
// one millisecond tick (s_tuser = 1). Commands: off, show volume, rainbow flash,
// or an unrecognised code that queues no redraw but still restarts the wait timer.
// Output channel (m_*): every redraw is LED_COUNT pixel words in pixel order,
// the final one marked with m_tlast.
// The front takes one input word per cycle while the two-entry redraw queue has
// room; the back walks the queue head, one pixel a cycle while the receiver takes
// them, and queued redraws follow each other with no gap.
// A redraw is registered in the queue, then each pixel in the output word register.
// When the receiver stalls, the current pixel word holds, the queue fills and
// s_tready drops; a word that causes no redraw still waits for queue room.
// Reset: mode off, resume mode off, colour 0, timer cleared and waiting for
// ever, hold 3000 ticks, rainbow step 1000 ticks, queue and output empty.
// Registers (APB, 32-bit): 0x0 volume hold ticks, 0x4 rainbow step ticks;
// write only while the block is idle.
module led_strip_effect_controller
#(
    parameter int LED_COUNT = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [1:0] command, [9:2] volume_level, rest zero
    input  logic        s_tuser,  // [0] op
    // Pixel words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [7:0] pixel_index, [14:8] red, [21:15] green,
                                  // [28:22] blue, rest zero
    output logic        m_tlast   // last_pixel
);

    localparam logic REG_VOLUME_HOLD  = 1'b0;
    localparam logic REG_RAINBOW_STEP = 1'b1;

    logic [15:0] hold_reg;
    logic [15:0] step_reg;
    logic        cfg_write;
    logic        accept;

    logic                    push;
    lsec_pkg::job_t          push_job;
    logic                    pop;
    lsec_pkg::job_t          head_job;
    lsec_pkg::queue_status_t status;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 16'd3000;
            step_reg <= 16'd1000;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_VOLUME_HOLD:  hold_reg <= pwdata[15:0];
                REG_RAINBOW_STEP: step_reg <= pwdata[15:0];
                default:          hold_reg <= hold_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_VOLUME_HOLD:  prdata = {16'd0, hold_reg};
            REG_RAINBOW_STEP: prdata = {16'd0, step_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Input handshake
    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;

    lsec_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .op              (s_tuser),
        .command         (s_tdata[1:0]),
        .volume_level    (s_tdata[9:2]),
        .volume_hold_ms  (hold_reg),
        .rainbow_step_ms (step_reg),
        .push            (push),
        .push_job        (push_job)
    );

    lsec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (status)
    );

    lsec_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .status   (status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/lsec_queue.sv =====
// Short queue of redraw jobs between the command front and the pixel back part.
module lsec_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lsec_pkg::job_t        push_job,
    input  logic                  pop,
    output lsec_pkg::job_t        head_job,
    output lsec_pkg::queue_status_t status
);

    lsec_pkg::job_t                 entry_reg [lsec_pkg::QUEUE_DEPTH];
    logic [lsec_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lsec_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [lsec_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lsec_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [lsec_pkg::QCNT_W-1:0]    count_reg;
    logic [lsec_pkg::QCNT_W-1:0]    count_next;

    localparam logic [lsec_pkg::QPTR_W-1:0] PTR_LAST =
        lsec_pkg::QPTR_W'(lsec_pkg::QUEUE_DEPTH - 1);
    localparam logic [lsec_pkg::QCNT_W-1:0] CNT_FULL =
        lsec_pkg::QCNT_W'(lsec_pkg::QUEUE_DEPTH);

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("redraw queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("redraw queue read while empty");

endmodule

// ===== rtl/lsec_front.sv =====
// Command front: accepts messages and ticks, keeps mode and timer, queues redraws.
module lsec_front
#(
    parameter int LED_COUNT = 30
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    op,
    input  logic [1:0]              command,
    input  logic [7:0]              volume_level,
    input  logic [15:0]             volume_hold_ms,
    input  logic [15:0]             rainbow_step_ms,
    output logic                    push,
    output lsec_pkg::job_t          push_job
);

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_VOLUME,
        MODE_RAINBOW,
        MODE_UNKNOWN
    } mode_t;

    typedef enum logic [1:0] {
        WAIT_FOREVER,
        WAIT_HOLD,
        WAIT_STEP
    } wait_t;

    localparam logic       OP_COMMAND = 1'b0;
    localparam logic [2:0] COLOUR_LAST = 3'd6;
    localparam logic [lsec_pkg::THRESH_W-1:0] ROUND_TERM = lsec_pkg::THRESH_W'(50);
    localparam logic [lsec_pkg::THRESH_W-1:0] LED_COUNT_W =
        lsec_pkg::THRESH_W'(LED_COUNT);

    mode_t       active_reg;
    mode_t       active_next;
    mode_t       resume_reg;
    mode_t       resume_next;
    wait_t       wait_reg;
    wait_t       wait_next;
    logic [2:0]  colour_reg;
    logic [2:0]  colour_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;

    logic        run;
    mode_t       run_mode;
    logic [7:0]  run_volume;
    logic [15:0] elapsed_inc;
    logic [15:0] limit;
    logic [2:0]  colour_sel;

    // Rainbow palette
    function automatic lsec_pkg::rgb_t palette(input logic [2:0] idx);
        lsec_pkg::rgb_t c;
        case (idx)
            3'd0:    c = '{lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_ZERO};
            3'd1:    c = '{lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_HALF, lsec_pkg::LEVEL_ZERO};
            3'd2:    c = '{lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_ZERO};
            3'd3:    c = '{lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_ZERO};
            3'd4:    c = '{lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_FULL};
            3'd5:    c = '{lsec_pkg::LEVEL_HALF, lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_FULL};
            3'd6:    c = '{lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_HALF};
            default: c = '{lsec_pkg::LEVEL_FULL, lsec_pkg::LEVEL_ZERO, lsec_pkg::LEVEL_ZERO};
        endcase
        return c;
    endfunction

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign limit       = (wait_reg == WAIT_HOLD) ? volume_hold_ms : rainbow_step_ms;
    assign colour_sel  = (colour_reg > COLOUR_LAST) ? 3'd0 : colour_reg;

    // Classify the word and update mode and timer
    always_comb
    begin
        active_next  = active_reg;
        resume_next  = resume_reg;
        wait_next    = wait_reg;
        colour_next  = colour_reg;
        elapsed_next = elapsed_reg;
        run          = 1'b0;
        run_mode     = active_reg;
        run_volume   = 8'd0;
        push         = 1'b0;
        push_job     = '0;

        if (accept)
        begin
            if (op == OP_COMMAND)
            begin
                if (active_reg != MODE_VOLUME)
                begin
                    resume_next = active_reg;
                end
                active_next  = mode_t'(command);
                elapsed_next = 16'd0;
                run          = 1'b1;
                run_mode     = mode_t'(command);
                run_volume   = volume_level;
            end
            else if (wait_reg == WAIT_HOLD || wait_reg == WAIT_STEP)
            begin
                if (elapsed_inc < limit)
                begin
                    elapsed_next = elapsed_inc;
                end
                else
                begin
                    elapsed_next = 16'd0;
                    if (active_reg == MODE_VOLUME)
                    begin
                        active_next = resume_reg;
                    end
                    run      = 1'b1;
                    run_mode = active_next;
                end
            end
        end

        // Run the selected mode: queue one redraw, or none for an unrecognised mode
        if (run)
        begin
            case (run_mode)
                MODE_OFF:
                begin
                    push      = 1'b1;
                    wait_next = WAIT_FOREVER;
                end
                MODE_VOLUME:
                begin
                    push               = 1'b1;
                    push_job.is_volume = 1'b1;
                    push_job.threshold = lsec_pkg::THRESH_W'(run_volume) * LED_COUNT_W
                                         + ROUND_TERM;
                    wait_next          = WAIT_HOLD;
                end
                MODE_RAINBOW:
                begin
                    push            = 1'b1;
                    push_job.colour = palette(colour_sel);
                    colour_next     = (colour_sel == COLOUR_LAST) ? 3'd0
                                                                  : colour_sel + 3'd1;
                    wait_next       = WAIT_STEP;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= MODE_OFF;
            resume_reg  <= MODE_OFF;
            wait_reg    <= WAIT_FOREVER;
            colour_reg  <= 3'd0;
            elapsed_reg <= 16'd0;
        end
        else
        begin
            active_reg  <= active_next;
            resume_reg  <= resume_next;
            wait_reg    <= wait_next;
            colour_reg  <= colour_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

// ===== rtl/lsec_back.sv =====
// Pixel back part: walks queued redraws, one pixel word per cycle unless stalled.
module lsec_back
#(
    parameter int LED_COUNT = 30
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lsec_pkg::job_t          head_job,
    input  lsec_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic                    m_tlast
);

    localparam logic [7:0] IDX_LAST = 8'(LED_COUNT - 1);
    localparam logic [lsec_pkg::THRESH_W-1:0] STEP = lsec_pkg::THRESH_W'(100);

    logic [7:0]                   idx_reg;
    logic [7:0]                   idx_next;
    logic [lsec_pkg::THRESH_W-1:0] acc_reg;
    logic [lsec_pkg::THRESH_W-1:0] acc_next;

    logic       out_valid_reg;
    logic [7:0] out_index_reg;
    logic [6:0] out_red_reg;
    logic [6:0] out_green_reg;
    logic [6:0] out_blue_reg;
    logic       out_last_reg;

    logic           advance;
    logic           emit;
    logic           lit;
    lsec_pkg::rgb_t pix;

    assign advance = !out_valid_reg || m_tready;
    assign emit    = advance && !status.empty;
    assign pop     = emit && (idx_reg == IDX_LAST);

    // Pixel idx is lit while (idx + 1) * 100 <= volume * count + 50
    assign lit = (acc_reg <= head_job.threshold);

    always_comb
    begin
        if (head_job.is_volume)
        begin
            pix.red   = lit ? lsec_pkg::LEVEL_FULL : lsec_pkg::LEVEL_ZERO;
            pix.green = pix.red;
            pix.blue  = pix.red;
        end
        else
        begin
            pix = head_job.colour;
        end
    end

    // Step through the strip
    always_comb
    begin
        idx_next = idx_reg;
        acc_next = acc_reg;
        if (emit)
        begin
            if (idx_reg == IDX_LAST)
            begin
                idx_next = 8'd0;
                acc_next = STEP;
            end
            else
            begin
                idx_next = idx_reg + 8'd1;
                acc_next = acc_reg + STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 8'd0;
            acc_reg       <= STEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            acc_reg <= acc_next;
            if (advance)
            begin
                out_valid_reg <= !status.empty;
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_index_reg <= idx_reg;
            out_red_reg   <= pix.red;
            out_green_reg <= pix.green;
            out_blue_reg  <= pix.blue;
            out_last_reg  <= (idx_reg == IDX_LAST);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_blue_reg, out_green_reg, out_red_reg, out_index_reg};

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_index_reg == IDX_LAST))
        else $error("last pixel flagged at wrong position");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && out_index_reg == $past(out_index_reg) + 8'd1))
        else $error("redraw broken before its last pixel");

endmodule
